@@ rtl/dtc_pkg.sv @@
// ----------------------------------------------------------------------------
// dtc_pkg - shared types and constants for the dense to CSR/CSC encoder
// Item descriptor, entry kind codes, register indexes and dimension limits.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int unsigned MaxDim     = 65536;
  localparam int unsigned DimW       = 17;
  localparam int unsigned PosW       = 16;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 33;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [DimW-1:0] MaxDimVal = DimW'(MaxDim);

  // Entry kind codes
  localparam logic KindValue   = 1'b0;
  localparam logic KindPointer = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgFormat  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumRows = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNumCols = 2'd2;

  // Beat select bits inside a descriptor's result mask
  localparam int unsigned BeatStart = 0;
  localparam int unsigned BeatValue = 1;
  localparam int unsigned BeatLine  = 2;

  // One classified item, handed from front to back
  typedef struct packed {
    logic [2:0]        beats;       // start pointer, value entry, line pointer
    logic              done;        // line pointer closes the matrix
    logic [WordW-1:0]  value;
    logic [PosW-1:0]   index;
    logic [CountW-1:0] count;       // nonzero count after this item
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > MaxDimVal) begin
      r = MaxDimVal;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/dtc_front.sv @@
// ----------------------------------------------------------------------------
// dtc_front - input classification and position tracking
// Holds the registers and the matrix position, classifies each item and
// pushes a descriptor of the results it causes.
// ----------------------------------------------------------------------------
module dtc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dtc_pkg::WordW-1:0]     weight_bits_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dtc_pkg::DimW-1:0]      cfg_data_i,
  input  dtc_pkg::fifo_stat_t           fifo_stat_i,
  output logic                          push_o,
  output dtc_pkg::desc_t                desc_o
);
  import dtc_pkg::*;

  logic              format_q, format_d;
  logic [DimW-1:0]   rows_q, rows_d, cols_q, cols_d;
  logic [PosW-1:0]   inner_q, inner_d, outer_q, outer_d;
  logic [CountW-1:0] count_q, count_d;

  logic [DimW-1:0]   inner_len, outer_len;
  logic [DimW-1:0]   inner_nxt, outer_nxt;
  logic              accept, start, nz, eol, done, restart;
  logic [CountW-1:0] count_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;

  assign inner_len = format_q ? clamp_dim(rows_q) : clamp_dim(cols_q);
  assign outer_len = format_q ? clamp_dim(cols_q) : clamp_dim(rows_q);
  assign inner_nxt = {1'b0, inner_q} + DimW'(1);
  assign outer_nxt = {1'b0, outer_q} + DimW'(1);

  assign start     = (inner_q == '0) && (outer_q == '0);
  assign nz        = |weight_bits_i[WordW-2:0];
  assign count_inc = count_q + CountW'(nz);
  assign eol       = inner_nxt >= inner_len;
  assign done      = eol && (outer_nxt >= outer_len);

  assign push_o       = accept && (start || nz || eol);
  assign desc_o.beats = {eol, nz, start};
  assign desc_o.done  = done;
  assign desc_o.value = weight_bits_i;
  assign desc_o.index = inner_q;
  assign desc_o.count = count_inc;

  always_comb begin
    format_d = format_q;
    rows_d   = rows_q;
    cols_d   = cols_q;
    restart  = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFormat:  begin format_d = cfg_data_i[0]; restart = 1'b1; end
        CfgNumRows: begin rows_d   = cfg_data_i;    restart = 1'b1; end
        CfgNumCols: begin cols_d   = cfg_data_i;    restart = 1'b1; end
        default:    ;
      endcase
    end
  end

  always_comb begin
    inner_d = inner_q;
    outer_d = outer_q;
    count_d = count_q;
    priority if (restart) begin
      inner_d = '0;
      outer_d = '0;
      count_d = '0;
    end else if (accept) begin
      if (done) begin
        inner_d = '0;
        outer_d = '0;
        count_d = '0;
      end else if (eol) begin
        inner_d = '0;
        outer_d = outer_nxt[PosW-1:0];
        count_d = count_inc;
      end else begin
        inner_d = inner_nxt[PosW-1:0];
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= 1'b0;
      rows_q   <= DimW'(1);
      cols_q   <= DimW'(1);
      inner_q  <= '0;
      outer_q  <= '0;
      count_q  <= '0;
    end else begin
      format_q <= format_d;
      rows_q   <= rows_d;
      cols_q   <= cols_d;
      inner_q  <= inner_d;
      outer_q  <= outer_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/dtc_fifo.sv @@
// ----------------------------------------------------------------------------
// dtc_fifo - short descriptor queue between front and back
// Register-based FIFO; push and pop may occur in the same cycle.
// ----------------------------------------------------------------------------
module dtc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dtc_pkg::desc_t      desc_i,
  input  logic                pop_i,
  output dtc_pkg::desc_t      desc_o,
  output dtc_pkg::fifo_stat_t stat_o
);
  import dtc_pkg::*;

  desc_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign stat_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign desc_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + FifoPtrW'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + FifoPtrW'(1) : rd_q;
    cnt_d = cnt_q + FifoCntW'(do_push) - FifoCntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

@@ rtl/dtc_back.sv @@
// ----------------------------------------------------------------------------
// dtc_back - result sequencer and output register
// Expands each descriptor into one to three results, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module dtc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dtc_pkg::fifo_stat_t         fifo_stat_i,
  input  dtc_pkg::desc_t              desc_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        entry_kind_o,
  output logic [dtc_pkg::WordW-1:0]   value_bits_o,
  output logic [dtc_pkg::PosW-1:0]    inner_index_o,
  output logic [dtc_pkg::CountW-1:0]  line_pointer_o,
  output logic                        matrix_done_o,
  output logic                        last_o
);
  import dtc_pkg::*;

  logic [2:0]        sent_q, sent_d;
  logic [2:0]        remain, pick;
  logic              load, is_last;
  logic              valid_q, valid_d;
  logic              kind_q, kind_d, done_q, done_d, last_q, last_d;
  logic [WordW-1:0]  value_q, value_d;
  logic [PosW-1:0]   index_q, index_d;
  logic [CountW-1:0] ptr_q, ptr_d;

  assign remain  = desc_i.beats & ~sent_q;
  assign pick    = remain & (~remain + 3'd1);   // lowest pending beat
  assign is_last = (remain == pick);
  assign load    = !fifo_stat_i.empty && (!valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_comb begin
    sent_d  = sent_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    done_d  = done_q;
    last_d  = last_q;
    value_d = value_q;
    index_d = index_q;
    ptr_d   = ptr_q;
    if (load) begin
      sent_d  = is_last ? 3'b000 : (sent_q | pick);
      valid_d = 1'b1;
      last_d  = is_last;
      kind_d  = KindPointer;
      done_d  = 1'b0;
      value_d = '0;
      index_d = '0;
      ptr_d   = '0;
      if (pick[BeatValue]) begin
        kind_d  = KindValue;
        value_d = desc_i.value;
        index_d = desc_i.index;
      end else if (pick[BeatLine]) begin
        ptr_d  = desc_i.count;
        done_d = desc_i.done;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      sent_q  <= sent_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    done_q  <= done_d;
    last_q  <= last_d;
    value_q <= value_d;
    index_q <= index_d;
    ptr_q   <= ptr_d;
  end

  assign out_valid_o    = valid_q;
  assign entry_kind_o   = kind_q;
  assign value_bits_o   = value_q;
  assign inner_index_o  = index_q;
  assign line_pointer_o = ptr_q;
  assign matrix_done_o  = done_q;
  assign last_o         = last_q;

endmodule

@@ rtl/dense_to_csr_csc_encoder.sv @@
// ----------------------------------------------------------------------------
// dense_to_csr_csc_encoder - dense weight stream to CSR/CSC entry stream
// Path: an item's descriptor is registered in the queue, each result in the output register.
// Throughput: one input item per cycle while each causes at most one result
//   and the output is ready; the results of one item leave one after another,
//   and the four-entry descriptor queue absorbs extra beats before input stalls.
// Reset: positions and count clear, format = CSR, rows = cols = 1, queue empty.
// ----------------------------------------------------------------------------
module dense_to_csr_csc_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dtc_pkg::WordW-1:0]   weight_bits_i,
  // register writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dtc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dtc_pkg::DimW-1:0]    cfg_data_i,
  // result item
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        entry_kind_o,
  output logic [dtc_pkg::WordW-1:0]   value_bits_o,
  output logic [dtc_pkg::PosW-1:0]    inner_index_o,
  output logic [dtc_pkg::CountW-1:0]  line_pointer_o,
  output logic                        matrix_done_o,
  output logic                        last_o
);
  import dtc_pkg::*;

  // Front to queue: one descriptor per item that causes any result
  logic       push;
  desc_t      push_desc;
  // Queue to back: head descriptor, popped after its last beat is loaded
  logic       pop;
  desc_t      head_desc;
  fifo_stat_t fifo_stat;

  // Track the position, classify the item, hold the registers
  dtc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .weight_bits_i (weight_bits_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .desc_o        (push_desc)
  );

  // Decouple the sides so input keeps flowing while pointer beats drain
  dtc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .desc_o (head_desc),
    .stat_o (fifo_stat)
  );

  // Expand descriptors into start pointer, value entry and line pointer
  dtc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_stat_i    (fifo_stat),
    .desc_i         (head_desc),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_kind_o   (entry_kind_o),
    .value_bits_o   (value_bits_o),
    .inner_index_o  (inner_index_o),
    .line_pointer_o (line_pointer_o),
    .matrix_done_o  (matrix_done_o),
    .last_o         (last_o)
  );

endmodule

@@ bench/csr_stream_checker.sv @@
// ----------------------------------------------------------------------------
// csr_stream_checker - scoreboard for the dense to CSR/CSC encoder
// Mirrors register writes, predicts the entries caused by every accepted
// weight item and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module csr_stream_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [dtc_pkg::WordW-1:0]   weight_bits_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [dtc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dtc_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic                        entry_kind_i,
  input  logic [dtc_pkg::WordW-1:0]   value_bits_i,
  input  logic [dtc_pkg::PosW-1:0]    inner_index_i,
  input  logic [dtc_pkg::CountW-1:0]  line_pointer_i,
  input  logic                        matrix_done_i,
  input  logic                        last_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);
  import dtc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [WordW-1:0]  value;
    logic [PosW-1:0]   index;
    logic [CountW-1:0] pointer;
    logic              done;
    logic              last;
  } entry_t;

  entry_t entries_due[$];

  logic              fmt_q;
  logic [DimW-1:0]   rows_q;
  logic [DimW-1:0]   cols_q;
  logic [PosW-1:0]   inner_q;
  logic [PosW-1:0]   outer_q;
  logic [CountW-1:0] nz_count_q;
  int unsigned       errors;
  int unsigned       results_seen;

  assign fail_count_o = errors;

  function automatic logic [DimW-1:0] limit_dim(input logic [DimW-1:0] d);
    if (d == '0) begin
      return DimW'(1);
    end
    if (d > DimW'(MaxDim)) begin
      return DimW'(MaxDim);
    end
    return d;
  endfunction

  task automatic restart_matrix();
    inner_q    = '0;
    outer_q    = '0;
    nz_count_q = '0;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0h want %0h",
             results_seen, what, got, want);
  endtask

  // Work out the entries one weight causes: start pointer, value, line pointer.
  task automatic encode_weight(input logic [WordW-1:0] w);
    entry_t          beats [3];
    int              n;
    logic [DimW-1:0] inner_len;
    logic [DimW-1:0] outer_len;
    logic            at_end;
    n = 0;
    inner_len = fmt_q ? limit_dim(rows_q) : limit_dim(cols_q);
    outer_len = fmt_q ? limit_dim(cols_q) : limit_dim(rows_q);
    if (inner_q == '0 && outer_q == '0) begin
      beats[n] = '0;
      beats[n].kind = KindPointer;
      n++;
    end
    // sign bit alone is negative zero
    if (w[WordW-2:0] != '0) begin
      beats[n] = '0;
      beats[n].kind  = KindValue;
      beats[n].value = w;
      beats[n].index = inner_q;
      n++;
      nz_count_q = nz_count_q + CountW'(1);
    end
    if ({1'b0, inner_q} + DimW'(1) >= inner_len) begin
      at_end = ({1'b0, outer_q} + DimW'(1) >= outer_len);
      beats[n] = '0;
      beats[n].kind    = KindPointer;
      beats[n].pointer = nz_count_q;
      beats[n].done    = at_end;
      n++;
      inner_q = '0;
      if (at_end) begin
        restart_matrix();
      end else begin
        outer_q = outer_q + PosW'(1);
      end
    end else begin
      inner_q = inner_q + PosW'(1);
    end
    for (int i = 0; i < n; i++) begin
      beats[i].last = (i == n - 1);
      entries_due.push_back(beats[i]);
    end
  endtask

  task automatic check_result();
    entry_t due;
    results_seen++;
    if (entries_due.size() == 0) begin
      flag_mismatch("result with nothing due, pointer", 64'(line_pointer_i), 64'd0);
    end else begin
      due = entries_due.pop_front();
      if (entry_kind_i !== due.kind) begin
        flag_mismatch("entry_kind", 64'(entry_kind_i), 64'(due.kind));
      end
      if (value_bits_i !== due.value) begin
        flag_mismatch("value_bits", 64'(value_bits_i), 64'(due.value));
      end
      if (inner_index_i !== due.index) begin
        flag_mismatch("inner_index", 64'(inner_index_i), 64'(due.index));
      end
      if (line_pointer_i !== due.pointer) begin
        flag_mismatch("line_pointer", 64'(line_pointer_i), 64'(due.pointer));
      end
      if (matrix_done_i !== due.done) begin
        flag_mismatch("matrix_done", 64'(matrix_done_i), 64'(due.done));
      end
      if (last_i !== due.last) begin
        flag_mismatch("last", 64'(last_i), 64'(due.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_due.delete();
      fmt_q  = 1'b0;
      rows_q = DimW'(1);
      cols_q = DimW'(1);
      restart_matrix();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgFormat: begin
            fmt_q = cfg_data_i[0];
            restart_matrix();
          end
          CfgNumRows: begin
            rows_q = cfg_data_i;
            restart_matrix();
          end
          CfgNumCols: begin
            cols_q = cfg_data_i;
            restart_matrix();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        encode_weight(weight_bits_i);
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      pending_o <= entries_due.size();
    end
  end

endmodule

@@ bench/dense_to_csr_csc_encoder_test.sv @@
// ----------------------------------------------------------------------------
// dense_to_csr_csc_encoder_test - top of the encoder testbench
// Drives weight items and register writes with random idling, stalls the
// result side at random and once for a long stretch, and leaves prediction
// and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module dense_to_csr_csc_encoder_test;
  import dtc_pkg::*;

  localparam int unsigned CycleLimit     = 3_000_000;
  localparam int unsigned RandomItems    = 410;
  localparam int unsigned SettleCycles   = 8;   // settle time for the queue and the output register
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned HoldItems      = 24;

  // index past the end of the register list; the block must ignore it
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [WordW-1:0]   weight    = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = CfgFormat;
  logic [DimW-1:0]    cfg_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               entry_kind;
  logic [WordW-1:0]   value_bits;
  logic [PosW-1:0]    inner_index;
  logic [CountW-1:0]  line_pointer;
  logic               matrix_done;
  logic               last;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycles         = 0;
  int unsigned stall_left     = 0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;

  dense_to_csr_csc_encoder u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .weight_bits_i  (weight),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .entry_kind_o   (entry_kind),
    .value_bits_o   (value_bits),
    .inner_index_o  (inner_index),
    .line_pointer_o (line_pointer),
    .matrix_done_o  (matrix_done),
    .last_o         (last)
  );

  csr_stream_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .weight_bits_i  (weight),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .entry_kind_i   (entry_kind),
    .value_bits_i   (value_bits),
    .inner_index_i  (inner_index),
    .line_pointer_i (line_pointer),
    .matrix_done_i  (matrix_done),
    .last_i         (last),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stop a hung run; the limit is many times the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: mostly ready, short random stalls, now and then a long one,
  // and exactly once a long hold-off so the block backs up into its input.
  always @(posedge clk) begin : receive_side
    int unsigned roll;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!long_hold_done && long_hold_req) begin
      stall_left     <= LongHoldCycles;
      long_hold_done <= 1'b1;
      out_ready      <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        stall_left <= $urandom_range(1, 3);
      end else if (roll < 24) begin
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Idle gap before an item: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 0;
    end
    if (roll < 95) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 40);
  endfunction

  // Weight mix: plenty of zeros and negative zeros so lines close with few
  // values, some special patterns (infinities, NaN, denormals), rest random.
  function automatic logic [WordW-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      return '0;
    end
    if (roll < 45) begin
      return 32'h8000_0000;
    end
    if (roll < 55) begin
      case ($urandom_range(0, 4))
        0:       return 32'h7F80_0000;
        1:       return 32'h7FC0_0000;
        2:       return 32'hFF80_0000;
        3:       return 32'h0000_0001;
        default: return 32'h807F_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // Dimensions: small mostly, so matrices complete often; rarely zero,
  // the maximum or beyond it, which the block clamps.
  function automatic logic [DimW-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return DimW'($urandom_range(1, 6));
    end
    if (roll < 88) begin
      return DimW'($urandom_range(7, 24));
    end
    if (roll < 94) begin
      return '0;
    end
    if (roll < 97) begin
      return DimW'(MaxDim);
    end
    return DimW'($urandom_range(MaxDim + 1, 131071));
  endfunction

  // Offer one item after an optional gap; leave valid high on acceptance so
  // a following item with no gap goes back to back.
  task automatic send_weight(input logic [WordW-1:0] w, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    weight   <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait until every predicted result has come, then let the
  // pipeline settle for items that caused none.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write while the block is idle; valid drops again before the task returns.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned        sent;
    int unsigned        phase_len;
    int unsigned        n_writes;
    logic               burst;
    logic [CfgIdxW-1:0] idx;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, CSR 1x1: every item is a whole matrix. Cover zero,
    // negative zero, NaN, a denormal, infinity and the smallest normal.
    send_weight(32'h0000_0000, pick_gap());
    send_weight(32'h8000_0000, pick_gap());
    send_weight(32'hFFFF_FFFF, pick_gap());
    send_weight(32'h0000_0001, pick_gap());
    send_weight(32'h7F80_0000, pick_gap());
    send_weight(32'h0080_0000, pick_gap());
    drain_results();

    // CSR 4x4 under the long hold-off: keep offering nonzero items back to
    // back so the queue fills and the input stalls.
    write_reg(CfgNumRows, DimW'(4));
    write_reg(CfgNumCols, DimW'(4));
    long_hold_req <= 1'b1;
    for (int h = 0; h < HoldItems; h++) begin
      send_weight(32'h4000_0000 | WordW'(h), 0);
    end
    drain_results();

    // CSC, 3 rows by 2 columns: one full matrix, then two items of the next.
    write_reg(CfgFormat, DimW'(1));
    write_reg(CfgNumRows, DimW'(3));
    write_reg(CfgNumCols, DimW'(2));
    send_weight(32'h3F80_0000, pick_gap());
    send_weight(32'h0000_0000, pick_gap());
    send_weight(32'h8000_0000, pick_gap());
    send_weight(32'h7FFF_FFFF, pick_gap());
    send_weight(32'h0000_0001, pick_gap());
    send_weight(32'h0000_0000, pick_gap());
    send_weight(32'hBF80_0000, pick_gap());
    send_weight(32'h0000_0000, pick_gap());
    drain_results();

    // Format takes only bit 0; zero rows reads as one. The write restarts
    // the half-done matrix above.
    write_reg(CfgFormat, 17'h1FFFE);
    write_reg(CfgNumRows, '0);
    write_reg(CfgNumCols, DimW'(4));
    send_weight(32'h0000_0005, pick_gap());
    send_weight(32'h0000_0000, pick_gap());
    drain_results();
    // Write past the register list mid-line: no restart, the line goes on.
    write_reg(CfgUnused, 17'h1FFFF);
    send_weight(32'h0000_0000, pick_gap());
    send_weight(32'h8000_0001, pick_gap());
    drain_results();

    // A width beyond the maximum reads as the maximum, so a short run of
    // items closes no line.
    write_reg(CfgNumCols, 17'h1FFFF);
    for (int i = 0; i < 16; i++) begin
      send_weight(pick_weight(), 0);
    end
    drain_results();

    // Random phases: a few register writes, then a run of items, some
    // phases without any input idling.
    sent = 0;
    while (sent < RandomItems) begin
      n_writes = $urandom_range(0, 3);
      for (int k = 0; k < n_writes; k++) begin
        idx = CfgIdxW'($urandom_range(0, 3));
        write_reg(idx, (idx == CfgFormat) ? DimW'($urandom_range(0, 131071)) : pick_dim());
      end
      burst     = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 50);
      for (int j = 0; j < phase_len; j++) begin
        send_weight(pick_weight(), burst ? 0 : pick_gap());
      end
      sent += phase_len;
      drain_results();
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
